[hw/rtl/srp_pkg.sv]
// Shared types and constants for the shelf rectangle packer.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package srp_pkg;

  // Fixed field widths
  localparam int RECT_BITS  = 14;
  localparam int PLACE_BITS = 14;
  localparam int PAGE_BITS  = 8;
  localparam int SIZE_BITS  = 15;
  localparam int GAP_BITS   = 8;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_MAX_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_MAX_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP             = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALLOW_TURN      = 2'd3;

  // Register reset values
  localparam logic [SIZE_BITS-1:0] PAGE_MAX_RESET = 15'd1024;
  localparam logic [GAP_BITS-1:0]  GAP_RESET      = 8'd0;

  // Last page index; the page counter saturates here
  localparam logic [PAGE_BITS-1:0] PAGE_LAST = 8'd255;

  // One placement result
  typedef struct packed {
    logic [PLACE_BITS-1:0] place_x;
    logic [PLACE_BITS-1:0] place_y;
    logic [PAGE_BITS-1:0]  page_index;
    logic                  turned;
    logic [SIZE_BITS-1:0]  used_width;
    logic [SIZE_BITS-1:0]  used_height;
    logic                  too_large;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/srp_channels.sv]
// Valid/ready channel interfaces for rectangle input and placement output.
// Depends on srp_pkg for field widths.
`default_nettype none

interface srp_rect_if
  import srp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [RECT_BITS-1:0] rect_width;
  logic [RECT_BITS-1:0] rect_height;
  logic                 start_set;

  modport source (output valid, rect_width, rect_height, start_set, input ready);
  modport sink   (input valid, rect_width, rect_height, start_set, output ready);
endinterface

interface srp_place_if
  import srp_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [PLACE_BITS-1:0] place_x;
  logic [PLACE_BITS-1:0] place_y;
  logic [PAGE_BITS-1:0]  page_index;
  logic                  turned;
  logic [SIZE_BITS-1:0]  used_width;
  logic [SIZE_BITS-1:0]  used_height;
  logic                  too_large;

  modport source (output valid, place_x, place_y, page_index, turned, used_width,
                  used_height, too_large, input ready);
  modport sink   (input valid, place_x, place_y, page_index, turned, used_width,
                  used_height, too_large, output ready);
endinterface

`default_nettype wire

[hw/rtl/shelf_rect_packer_unit.sv]
// Top level of the next-fit shelf rectangle packer.
// Depends on srp_pkg and the channel interfaces in srp_channels.sv.
`default_nettype none

// Places one rectangle per beat on shelves of atlas pages, next-fit: to the
// right on the current row, else on a new row below, else at the top-left of
// a new page. One rectangle is accepted every clock cycle unless the skid
// entry of the two-entry output buffer is full; the result is registered into
// the output register, or into the skid entry while the output is stalled.
// The placement logic on the cursor and page-size registers is combinational.
// A rectangle whose unrotated size plus twice the gap exceeds the page limits
// is reported with too_large set and leaves the packing state unchanged.
// Configuration writes are taken at any time but must only occur while the
// block holds no undelivered result.
module shelf_rect_packer_unit
  import srp_pkg::*;
#(
  parameter int COORD_BITS = 15
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_write,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data,
  srp_rect_if.sink                  in_rect,
  srp_place_if.source               out_place
);

  // Working width for sums of cursor, size and gap
  localparam int SW = ((COORD_BITS > RECT_BITS) ? COORD_BITS : RECT_BITS) + 2;

  // Configuration registers
  logic [SIZE_BITS-1:0] page_max_width;
  logic [SIZE_BITS-1:0] page_max_height;
  logic [GAP_BITS-1:0]  gap;
  logic                 allow_turn;

  // Packing state
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [COORD_BITS-1:0] page_width_now;
  logic [COORD_BITS-1:0] page_height_now;
  logic [PAGE_BITS-1:0]  page_count;

  logic [COORD_BITS-1:0] cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y_next;
  logic [COORD_BITS-1:0] page_width_now_next;
  logic [COORD_BITS-1:0] page_height_now_next;
  logic [PAGE_BITS-1:0]  page_count_next;

  // Output buffer
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  result_t res;

  logic take;
  logic out_take;

  // Placement datapath
  logic [SW-1:0]         g2;
  logic [SW-1:0]         gap_w;
  logic                  too_big;
  logic                  turn;
  logic [SW-1:0]         w;
  logic [SW-1:0]         h;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [COORD_BITS-1:0] pw;
  logic [COORD_BITS-1:0] ph;
  logic [PAGE_BITS-1:0]  pc;
  logic [SW-1:0]         right_row;
  logic [SW-1:0]         right_new;
  logic [SW-1:0]         row;
  logic [SW-1:0]         bottom_new_row;
  logic                  fits_row;
  logic                  fits_col;
  logic [SW-1:0]         px;
  logic [SW-1:0]         py;
  logic [SW-1:0]         right;
  logic [SW-1:0]         bottom;
  logic [COORD_BITS-1:0] base_w;
  logic [COORD_BITS-1:0] base_h;

  assign take     = in_rect.valid && in_rect.ready;
  assign out_take = out_valid && out_place.ready;
  assign in_rect.ready = !skid_valid;

  // Compute the placement of the offered rectangle
  always_comb begin
    g2    = SW'(gap) << 1;
    gap_w = SW'(gap);
    too_big = ((SW'(in_rect.rect_width) + g2) > SW'(page_max_width)) ||
              ((SW'(in_rect.rect_height) + g2) > SW'(page_max_height));

    turn = allow_turn && (in_rect.rect_width > in_rect.rect_height);
    w = turn ? SW'(in_rect.rect_height) : SW'(in_rect.rect_width);
    h = turn ? SW'(in_rect.rect_width) : SW'(in_rect.rect_height);

    // A new run starts from cleared state
    cx = in_rect.start_set ? '0 : cursor_x;
    cy = in_rect.start_set ? '0 : cursor_y;
    pw = in_rect.start_set ? '0 : page_width_now;
    ph = in_rect.start_set ? '0 : page_height_now;
    pc = in_rect.start_set ? '0 : page_count;

    right_row = g2 + SW'(cx) + w;
    fits_row  = right_row <= SW'(page_max_width);
    row       = (SW'(ph) > gap_w) ? (SW'(ph) - gap_w) : '0;
    bottom_new_row = g2 + row + h;
    right_new = g2 + w;
    fits_col  = bottom_new_row <= SW'(page_max_height);

    page_count_next = pc;
    if (fits_row) begin
      cursor_y_next = cy;
      px     = SW'(cx) + gap_w;
      py     = SW'(cy) + gap_w;
      right  = right_row;
      bottom = g2 + SW'(cy) + h;
      base_w = pw;
      base_h = ph;
    end else if (fits_col) begin
      cursor_y_next = row[COORD_BITS-1:0];
      px     = gap_w;
      py     = row + gap_w;
      right  = right_new;
      bottom = bottom_new_row;
      base_w = pw;
      base_h = ph;
    end else begin
      // Open a new page
      cursor_y_next = '0;
      px     = gap_w;
      py     = gap_w;
      right  = right_new;
      bottom = g2 + h;
      base_w = '0;
      base_h = h[COORD_BITS-1:0];
      if (pc != PAGE_LAST) begin
        page_count_next = pc + 8'd1;
      end
    end

    // Grow the page to cover the new rectangle
    page_width_now_next  = (SW'(base_w) < right) ? right[COORD_BITS-1:0] : base_w;
    page_height_now_next = (SW'(base_h) < bottom) ? bottom[COORD_BITS-1:0] : base_h;
    cursor_x_next = right[COORD_BITS-1:0];

    // Result of this beat
    if (too_big) begin
      res.place_x     = '0;
      res.place_y     = '0;
      res.page_index  = page_count;
      res.turned      = 1'b0;
      res.used_width  = SIZE_BITS'(page_width_now);
      res.used_height = SIZE_BITS'(page_height_now);
      res.too_large   = 1'b1;
    end else begin
      res.place_x     = px[PLACE_BITS-1:0];
      res.place_y     = py[PLACE_BITS-1:0];
      res.page_index  = page_count_next;
      res.turned      = turn;
      res.used_width  = SIZE_BITS'(page_width_now_next);
      res.used_height = SIZE_BITS'(page_height_now_next);
      res.too_large   = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_max_width  <= PAGE_MAX_RESET;
      page_max_height <= PAGE_MAX_RESET;
      gap             <= GAP_RESET;
      allow_turn      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAGE_MAX_WIDTH:  page_max_width  <= cfg_data[SIZE_BITS-1:0];
        REG_PAGE_MAX_HEIGHT: page_max_height <= cfg_data[SIZE_BITS-1:0];
        REG_GAP:             gap             <= cfg_data[GAP_BITS-1:0];
        REG_ALLOW_TURN:      allow_turn      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance packing state on each placed rectangle
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x        <= '0;
      cursor_y        <= '0;
      page_width_now  <= '0;
      page_height_now <= '0;
      page_count      <= '0;
    end else if (take && !too_big) begin
      cursor_x        <= cursor_x_next;
      cursor_y        <= cursor_y_next;
      page_width_now  <= page_width_now_next;
      page_height_now <= page_height_now_next;
      page_count      <= page_count_next;
    end
  end

  // Output buffer control: main register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (take) begin
        out_data <= res;
      end
    end else if (take) begin
      skid_data <= res;
    end
  end

  assign out_place.valid       = out_valid;
  assign out_place.place_x     = out_data.place_x;
  assign out_place.place_y     = out_data.place_y;
  assign out_place.page_index  = out_data.page_index;
  assign out_place.turned      = out_data.turned;
  assign out_place.used_width  = out_data.used_width;
  assign out_place.used_height = out_data.used_height;
  assign out_place.too_large   = out_data.too_large;

endmodule

`default_nettype wire
